[rtl/lusf_pkg.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// lusf_pkg: shared types and constants of the luma sharpening filter
// Field widths, register codes and reset values, the result job and bundle
// types passed from the front end through the queue to the back end, and
// the cross Laplacian helper.
// ----------------------------------------------------------------------------
package lusf_pkg;

	localparam int PIX_W          = 8;
	localparam int CFG_W          = 12;
	localparam int IDX_W          = 2;
	localparam int HP_W           = 11;
	localparam int SUM_W          = 12;
	localparam int GAIN_FRAC      = 8;
	localparam int PROD_W         = 24;
	localparam int JOBS           = 3;
	localparam int QUEUE_DEPTH    = 4;
	localparam int DEF_MAX_WIDTH  = 2048;
	localparam int DEF_MAX_HEIGHT = 2048;

	// Register indexes on the configuration port
	localparam logic [IDX_W-1:0] REG_GAIN   = 2'd0;
	localparam logic [IDX_W-1:0] REG_WIDTH  = 2'd1;
	localparam logic [IDX_W-1:0] REG_HEIGHT = 2'd2;

	localparam logic [CFG_W-1:0] GAIN_RESET   = 12'd0;
	localparam logic [CFG_W-1:0] WIDTH_RESET  = 12'd2048;
	localparam logic [CFG_W-1:0] HEIGHT_RESET = 12'd2048;

	localparam logic [PIX_W-1:0] PIX_MAX = 8'd255;

	// One output pixel to produce: center value, high-pass term (zero for
	// a pass-through pixel) and the end-of-frame mark
	typedef struct packed {
		logic [PIX_W-1:0] c;
		logic [HP_W-1:0]  hp;
		logic             last;
	} job_t;

	// All results caused by one input item, oldest at index 0
	typedef struct packed {
		logic [JOBS-1:0] valid;
		job_t [JOBS-1:0] job;
	} bundle_t;

	// 4c - l - r - u - d; the true value fits HP_W bits two's complement,
	// so modular arithmetic on SUM_W bits is exact
	function automatic logic [HP_W-1:0] laplace(
		input logic [PIX_W-1:0] c,
		input logic [PIX_W-1:0] l,
		input logic [PIX_W-1:0] r,
		input logic [PIX_W-1:0] u,
		input logic [PIX_W-1:0] d
	);
		logic [SUM_W-1:0] s;
		s = SUM_W'({c, 2'b00}) - SUM_W'(l) - SUM_W'(r) - SUM_W'(u) - SUM_W'(d);
		return s[HP_W-1:0];
	endfunction

endpackage

[rtl/lusf_front.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// lusf_front: pixel intake, position tracking and window assembly
// Accepts pixels, clamps the raster position to the frame size, reads the
// two row stores, classifies each pixel and forms the bundle of up to three
// result jobs that it causes, then pushes the bundle into the queue.
// ----------------------------------------------------------------------------
module lusf_front import lusf_pkg::*; #(
	parameter int MAX_WIDTH  = DEF_MAX_WIDTH,
	parameter int MAX_HEIGHT = DEF_MAX_HEIGHT
) (
	input  logic             clk,
	input  logic             arst_n,
	input  logic [CFG_W-1:0] cfg_width,
	input  logic [CFG_W-1:0] cfg_height,
	input  logic             pixel_valid,
	output logic             pixel_ready,
	input  logic [PIX_W-1:0] luma_in,
	output logic             push,
	output bundle_t          bundle,
	input  logic             q_full
);

	localparam int AW  = $clog2(MAX_WIDTH);
	localparam int WW  = $clog2(MAX_WIDTH + 1);
	localparam int HW  = (MAX_HEIGHT > 1) ? $clog2(MAX_HEIGHT) : 1;
	localparam int HHW = $clog2(MAX_HEIGHT + 1);

	typedef struct packed {
		logic up_row;
		logic y_is0;
		logic y_is1;
		logic last_row;
		logic x_is0;
		logic x_is1;
		logic x_last;
		logic narrow;
	} cls_t;

	logic [31:0]      w_full, h_full;
	logic [WW-1:0]    w_cur, wm1;
	logic [HHW-1:0]   h_cur, hm1;
	logic [AW-1:0]    cc_q, x_cur, rd_x1;
	logic [HW-1:0]    rc_q, y_cur;
	cls_t             cls_now, cls_s1;
	logic             acc, s1_adv, any_job;
	logic             v_s1;
	logic [AW-1:0]    x_s1;
	logic [PIX_W-1:0] p_s1;
	logic [PIX_W-1:0] newer_rd0_s1, newer_rd1_s1, older_rd_s1;
	logic             byp_a_q, byp_r_q;
	logic [PIX_W-1:0] byp_new_q, byp_old_q;
	logic [PIX_W-1:0] wr0_q, wr1_q, wr2_q;
	logic [PIX_W-1:0] a_eff, b_eff, r_eff;
	logic [PIX_W-1:0] row_newer_q [MAX_WIDTH];
	logic [PIX_W-1:0] row_older_q [MAX_WIDTH];

	// Clamp frame size and position
	always_comb begin
		w_full = (cfg_width == '0) ? 32'd1 :
			((32'(cfg_width) > 32'(MAX_WIDTH)) ? 32'(MAX_WIDTH) : 32'(cfg_width));
		h_full = (cfg_height == '0) ? 32'd1 :
			((32'(cfg_height) > 32'(MAX_HEIGHT)) ? 32'(MAX_HEIGHT) : 32'(cfg_height));
		w_cur = WW'(w_full);
		h_cur = HHW'(h_full);
		wm1   = w_cur - WW'(1);
		hm1   = h_cur - HHW'(1);
		x_cur = (WW'(cc_q) < w_cur) ? cc_q : AW'(wm1);
		y_cur = (HHW'(rc_q) < h_cur) ? rc_q : HW'(hm1);
		rd_x1 = x_cur + AW'(1);
	end

	// Classify the arriving pixel
	always_comb begin
		cls_now.up_row   = (y_cur != '0);
		cls_now.y_is0    = (y_cur == '0);
		cls_now.y_is1    = (y_cur == HW'(1));
		cls_now.last_row = (HHW'(y_cur) == hm1);
		cls_now.x_is0    = (x_cur == '0);
		cls_now.x_is1    = (x_cur == AW'(1));
		cls_now.x_last   = (WW'(x_cur) == wm1);
		cls_now.narrow   = (w_cur <= WW'(2));
	end

	// Forward the item leaving stage 1 when its write collides with a read
	always_comb begin
		a_eff = byp_a_q ? byp_new_q : newer_rd0_s1;
		b_eff = byp_a_q ? byp_old_q : older_rd_s1;
		r_eff = byp_r_q ? byp_new_q : newer_rd1_s1;
	end

	// Build the result bundle
	always_comb begin
		bundle = '0;
		bundle.valid[0]    = cls_s1.up_row;
		bundle.job[0].c    = a_eff;
		bundle.job[0].hp   = (cls_s1.x_is0 || cls_s1.x_last || cls_s1.narrow) ? '0 :
			laplace(a_eff, wr0_q, r_eff, cls_s1.y_is1 ? a_eff : b_eff, p_s1);
		bundle.job[0].last = 1'b0;
		bundle.valid[1]    = cls_s1.last_row && !cls_s1.x_is0;
		bundle.job[1].c    = wr1_q;
		bundle.job[1].hp   = (cls_s1.x_is1 || cls_s1.narrow) ? '0 :
			laplace(wr1_q, wr2_q, p_s1, cls_s1.y_is0 ? wr1_q : wr0_q, wr1_q);
		bundle.job[1].last = 1'b0;
		bundle.valid[2]    = cls_s1.last_row && cls_s1.x_last;
		bundle.job[2].c    = p_s1;
		bundle.job[2].hp   = '0;
		bundle.job[2].last = 1'b1;
	end

	assign any_job     = |bundle.valid;
	assign s1_adv      = v_s1 && (!any_job || !q_full);
	assign push        = v_s1 && any_job && !q_full;
	assign pixel_ready = !v_s1 || s1_adv;
	assign acc         = pixel_valid && pixel_ready;

	// Control: position counters, stage valid, forwarding flags
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cc_q    <= '0;
			rc_q    <= '0;
			v_s1    <= 1'b0;
			byp_a_q <= 1'b0;
			byp_r_q <= 1'b0;
			wr0_q   <= '0;
			wr1_q   <= '0;
			wr2_q   <= '0;
		end else begin
			if (acc) begin
				v_s1    <= 1'b1;
				byp_a_q <= s1_adv && (x_cur == x_s1);
				byp_r_q <= s1_adv && (rd_x1 == x_s1);
				if (cls_now.x_last) begin
					cc_q <= '0;
					rc_q <= cls_now.last_row ? '0 : y_cur + HW'(1);
				end else begin
					cc_q <= x_cur + AW'(1);
					rc_q <= y_cur;
				end
			end else if (s1_adv) begin
				v_s1 <= 1'b0;
			end
			// Advance the window as each item retires from stage 1
			if (s1_adv) begin
				wr0_q <= a_eff;
				wr2_q <= wr1_q;
				wr1_q <= p_s1;
			end
		end
	end

	// Stage 1 payload and forwarding data
	always_ff @(posedge clk) begin
		if (acc) begin
			x_s1      <= x_cur;
			p_s1      <= luma_in;
			cls_s1    <= cls_now;
			byp_new_q <= p_s1;
			byp_old_q <= a_eff;
		end
	end

	// Row stores: write the retiring item, read for the arriving one
	always_ff @(posedge clk) begin
		if (s1_adv) begin
			row_newer_q[x_s1] <= p_s1;
			row_older_q[x_s1] <= a_eff;
		end
		if (acc) begin
			newer_rd0_s1 <= row_newer_q[x_cur];
			newer_rd1_s1 <= row_newer_q[rd_x1];
			older_rd_s1  <= row_older_q[x_cur];
		end
	end

endmodule

[rtl/lusf_queue.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// lusf_queue: bundle queue between front and back end
// A small register FIFO that lets the front keep taking pixels while the
// back end drains bundles of several results.
// ----------------------------------------------------------------------------
module lusf_queue import lusf_pkg::*; (
	input  logic    clk,
	input  logic    arst_n,
	input  logic    push,
	input  bundle_t push_data,
	output logic    full,
	input  logic    pop,
	output logic    empty,
	output bundle_t head
);

	localparam int PW = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
	localparam int CW = $clog2(QUEUE_DEPTH + 1);

	bundle_t        mem_q [QUEUE_DEPTH];
	logic [PW-1:0]  wp_q, rp_q;
	logic [CW-1:0]  cnt_q;
	logic           do_push, do_pop;

	assign full    = (cnt_q == CW'(QUEUE_DEPTH));
	assign empty   = (cnt_q == '0);
	assign head    = mem_q[rp_q];
	assign do_push = push && !full;
	assign do_pop  = pop && !empty;

	// Pointers and fill count
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wp_q  <= '0;
			rp_q  <= '0;
			cnt_q <= '0;
		end else begin
			if (do_push) begin
				wp_q <= (wp_q == PW'(QUEUE_DEPTH - 1)) ? '0 : wp_q + PW'(1);
			end
			if (do_pop) begin
				rp_q <= (rp_q == PW'(QUEUE_DEPTH - 1)) ? '0 : rp_q + PW'(1);
			end
			case ({do_push, do_pop})
				2'b10:   cnt_q <= cnt_q + CW'(1);
				2'b01:   cnt_q <= cnt_q - CW'(1);
				default: cnt_q <= cnt_q;
			endcase
		end
	end

	// Entry storage
	always_ff @(posedge clk) begin
		if (do_push) begin
			mem_q[wp_q] <= push_data;
		end
	end

endmodule

[rtl/lusf_back.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// lusf_back: result computation and output register
// Unpacks each bundle one job per cycle unless stalled, multiplies the
// high-pass term by gain, shifts, adds center, clamps into output register.
// ----------------------------------------------------------------------------
module lusf_back import lusf_pkg::*; (
	input  logic             clk,
	input  logic             arst_n,
	input  logic [CFG_W-1:0] gain,
	input  bundle_t          head,
	input  logic             empty,
	output logic             pop,
	output logic             result_valid,
	input  logic             result_ready,
	output logic [PIX_W-1:0] luma_out,
	output logic             frame_last
);

	localparam int JI = $clog2(JOBS);

	logic [JOBS-1:0]          done_q, pend, pick, rest;
	logic [JI-1:0]            idx;
	job_t                     job_sel;
	logic                     issue, en_s1, en_s2, en_out;
	logic                     v_s1, v_s2, res_v_q;
	logic [PIX_W-1:0]         c_s1, c_s2, luma_q;
	logic [HP_W-1:0]          hp_s1;
	logic                     last_s1, last_s2, last_q;
	logic signed [PROD_W-1:0] prod, prod_s2, sum;

	// Pick the oldest job of the head bundle not yet issued
	always_comb begin
		pend = head.valid & ~done_q;
		idx  = '0;
		for (int i = JOBS - 1; i >= 0; i--) begin
			if (pend[i]) begin
				idx = JI'(i);
			end
		end
		pick    = JOBS'(1) << idx;
		rest    = pend & ~pick;
		job_sel = head.job[idx];
	end

	assign en_out = !res_v_q || result_ready;
	assign en_s2  = !v_s2 || en_out;
	assign en_s1  = !v_s1 || en_s2;
	assign issue  = !empty && en_s1;
	assign pop    = issue && (rest == '0);

	assign prod = $signed({1'b0, gain}) * $signed(hp_s1);

	// Arithmetic shift floors, then add center; the clamp is in the output register
	always_comb begin
		sum = $signed(PROD_W'(c_s2)) + (prod_s2 >>> GAIN_FRAC);
	end

	// Control: issue mask and stage valids
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			done_q  <= '0;
			v_s1    <= 1'b0;
			v_s2    <= 1'b0;
			res_v_q <= 1'b0;
		end else begin
			if (issue) begin
				done_q <= (rest == '0) ? '0 : (done_q | pick);
			end
			if (en_s1) begin
				v_s1 <= issue;
			end
			if (en_s2) begin
				v_s2 <= v_s1;
			end
			if (en_out) begin
				res_v_q <= v_s2;
			end
		end
	end

	// Payload pipeline
	always_ff @(posedge clk) begin
		if (en_s1 && issue) begin
			c_s1    <= job_sel.c;
			hp_s1   <= job_sel.hp;
			last_s1 <= job_sel.last;
		end
		if (en_s2 && v_s1) begin
			c_s2    <= c_s1;
			prod_s2 <= prod;
			last_s2 <= last_s1;
		end
		if (en_out && v_s2) begin
			last_q <= last_s2;
			if (sum < 0) begin
				luma_q <= '0;
			end else if (sum > $signed(PROD_W'(PIX_MAX))) begin
				luma_q <= PIX_MAX;
			end else begin
				luma_q <= sum[PIX_W-1:0];
			end
		end
	end

	assign result_valid = res_v_q;
	assign luma_out     = luma_q;
	assign frame_last   = last_q;

endmodule

[rtl/luma_unsharp_sharpen_filter.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// luma_unsharp_sharpen_filter: 3x3 cross Laplacian luma sharpener
// Path: the pixel that completes a window is registered in front stage 1;
//   its result passes the queue, back s1, back s2 and the output register.
// Throughput: one pixel per cycle while the queue has room; last-row pixels
//   but the first give two results each and the final pixel three, so once
//   the 4-bundle queue fills, the output paces at one result per ready cycle.
// Reset: counters, window and pipeline clear, registers take their defaults;
//   the row stores are not cleared and hold nothing valid until written.
// ----------------------------------------------------------------------------
module luma_unsharp_sharpen_filter import lusf_pkg::*; #(
	parameter int MAX_WIDTH  = DEF_MAX_WIDTH,
	parameter int MAX_HEIGHT = DEF_MAX_HEIGHT
) (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             cfg_valid,
	output logic             cfg_ready,
	input  logic [IDX_W-1:0] cfg_index,
	input  logic [CFG_W-1:0] cfg_data,
	input  logic             pixel_valid,
	output logic             pixel_ready,
	input  logic [PIX_W-1:0] luma_in,
	output logic             result_valid,
	input  logic             result_ready,
	output logic [PIX_W-1:0] luma_out,
	output logic             frame_last
);

	logic [CFG_W-1:0] gain_q, width_q, height_q;
	logic             q_push, q_full, q_pop, q_empty;
	bundle_t          q_in, q_head;

	assign cfg_ready = 1'b1;

	// Configuration registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			gain_q   <= GAIN_RESET;
			width_q  <= WIDTH_RESET;
			height_q <= HEIGHT_RESET;
		end else if (cfg_valid) begin
			unique case (cfg_index)
				REG_GAIN:   gain_q   <= cfg_data;
				REG_WIDTH:  width_q  <= cfg_data;
				REG_HEIGHT: height_q <= cfg_data;
				default:    ;
			endcase
		end
	end

	lusf_front #(
		.MAX_WIDTH  (MAX_WIDTH),
		.MAX_HEIGHT (MAX_HEIGHT)
	) u_front (
		.clk         (clk),
		.arst_n      (arst_n),
		.cfg_width   (width_q),
		.cfg_height  (height_q),
		.pixel_valid (pixel_valid),
		.pixel_ready (pixel_ready),
		.luma_in     (luma_in),
		.push        (q_push),
		.bundle      (q_in),
		.q_full      (q_full)
	);

	lusf_queue u_queue (
		.clk       (clk),
		.arst_n    (arst_n),
		.push      (q_push),
		.push_data (q_in),
		.full      (q_full),
		.pop       (q_pop),
		.empty     (q_empty),
		.head      (q_head)
	);

	lusf_back u_back (
		.clk          (clk),
		.arst_n       (arst_n),
		.gain         (gain_q),
		.head         (q_head),
		.empty        (q_empty),
		.pop          (q_pop),
		.result_valid (result_valid),
		.result_ready (result_ready),
		.luma_out     (luma_out),
		.frame_last   (frame_last)
	);

	// Front never pushes into a full queue
	a_no_overflow: assert property (@(posedge clk) disable iff (!arst_n)
		q_push |-> !q_full)
		else $error("bundle pushed into full queue");

	// Back never retires a bundle from an empty queue
	a_no_underflow: assert property (@(posedge clk) disable iff (!arst_n)
		q_pop |-> !q_empty)
		else $error("bundle popped from empty queue");

	// Intake stalls only on back pressure from the queue
	a_stall_cause: assert property (@(posedge clk) disable iff (!arst_n)
		!pixel_ready |-> q_full)
		else $error("pixel intake stalled without a full queue");

endmodule
